// File: rtl/qrs_pkg.sv
// qrs_pkg: shared constants and types for the quadratic root solver
// depends on nothing; imported by every qrs module and the top level
`default_nettype none
package qrs_pkg;
    localparam int DEF_FRAC_BITS = 16;
    localparam int COEF_W = 32;
    localparam int DISC_W = 67;
    localparam int SQRT_W = 34;
    localparam int NUM_W = 36;
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_ONE  = 2'd1,
        ST_TWO  = 2'd2,
        ST_AZERO = 2'd3
    } status_t;

    // classified item handed from front to back
    typedef struct packed {
        status_t              status;
        logic [DISC_W-2:0]    disc;
        logic signed [COEF_W:0] negb;
        logic [COEF_W-1:0]    mag_a;
        logic                 a_neg;
    } job_t;
endpackage
`default_nettype wire

// File: rtl/quadratic_root_solver.sv
// quadratic_root_solver: fixed point real roots of a*x^2 + b*x + c
// pipeline: 95 stages: 3 front, 1 queue, 35 sqrt, 2 round, 53 divide, 1 output
// throughput: one item per cycle; busy never rises, results cannot be stalled
// reset: rst_n clears all valid bits and queue pointers, payload is not reset
`default_nettype none
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [COEF_W-1:0] coef_a,
    input  wire logic signed [COEF_W-1:0] coef_b,
    input  wire logic signed [COEF_W-1:0] coef_c,
    output logic                    done,
    output logic [1:0]              root_status,
    output logic signed [COEF_W-1:0] root_plus,
    output logic signed [COEF_W-1:0] root_minus,
    output logic                    saturated
);
    logic    acc;
    logic    fv;
    job_t    fj, qj;
    logic    qne;
    status_t st;

    // back end is fully pipelined, so the queue drains every cycle
    assign busy = 1'b0;
    assign acc  = start & ~busy;

    qrs_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(acc),
        .a(coef_a), .b(coef_b), .c(coef_c),
        .out_valid(fv), .out_job(fj)
    );

    qrs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(fv), .wr_data(fj),
        .rd_en(qne), .rd_data(qj), .not_empty(qne)
    );

    qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(qne), .in_job(qj),
        .out_valid(done), .out_status(st),
        .out_plus(root_plus), .out_minus(root_minus), .out_sat(saturated)
    );

    assign root_status = st;

    // a result with no real roots carries zero roots
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (root_status == ST_NONE || root_status == ST_AZERO)
            |-> (root_plus == '0 && root_minus == '0 && !saturated))
        else $error("roots not zero for rootless result");

    // single root reported in both fields
    a_one_same: assert property (@(posedge clk) disable iff (!rst_n)
        done && root_status == ST_ONE |-> root_plus == root_minus)
        else $error("single root mismatch");

    // queue never holds more than one item since it drains each cycle
    a_q_drain: assert property (@(posedge clk) disable iff (!rst_n)
        qne |=> !qne || $past(fv))
        else $error("queue not draining");
endmodule
`default_nettype wire

// File: rtl/qrs_front.sv
// qrs_front: three-stage pipeline that forms b*b - 4ac and classifies each item
// depends on qrs_pkg
`default_nettype none
module qrs_front
    import qrs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic signed [COEF_W-1:0] a,
    input  wire logic signed [COEF_W-1:0] b,
    input  wire logic signed [COEF_W-1:0] c,
    output logic                          out_valid,
    output job_t                          out_job
);
    logic [2:0]             v_reg;
    logic [COEF_W-1:0]      ua_reg, ub_reg, uc_reg, ua2_reg, ua3_reg;
    logic                   an_reg, an2_reg, an3_reg, acn_reg, az_reg, az2_reg, az3_reg;
    logic signed [COEF_W:0] nb_reg, nb2_reg, nb3_reg;
    logic [63:0]            b2_reg, p_reg;
    logic                   acn2_reg;
    logic [DISC_W-1:0]      d_reg;
    logic [DISC_W-1:0]      d_next;

    always_comb
    begin
        if (acn2_reg)
            d_next = {3'b0, b2_reg} + {1'b0, p_reg, 2'b0};
        else
            d_next = {3'b0, b2_reg} - {1'b0, p_reg, 2'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        ua_reg  <= a[COEF_W-1] ? COEF_W'(-a) : COEF_W'(a);
        ub_reg  <= b[COEF_W-1] ? COEF_W'(-b) : COEF_W'(b);
        uc_reg  <= c[COEF_W-1] ? COEF_W'(-c) : COEF_W'(c);
        an_reg  <= a[COEF_W-1];
        acn_reg <= (a[COEF_W-1] != c[COEF_W-1]) && (a != '0) && (c != '0);
        az_reg  <= (a == '0);
        nb_reg  <= -{b[COEF_W-1], b};
        // stage 2: products
        b2_reg   <= ub_reg * ub_reg;
        p_reg    <= ua_reg * uc_reg;
        acn2_reg <= acn_reg;
        ua2_reg  <= ua_reg;
        an2_reg  <= an_reg;
        az2_reg  <= az_reg;
        nb2_reg  <= nb_reg;
        // stage 3: discriminant
        d_reg   <= d_next;
        ua3_reg <= ua2_reg;
        an3_reg <= an2_reg;
        az3_reg <= az2_reg;
        nb3_reg <= nb2_reg;
    end

    always_comb
    begin
        out_valid      = v_reg[2];
        out_job.disc   = d_reg[DISC_W-2:0];
        out_job.negb   = nb3_reg;
        out_job.mag_a  = ua3_reg;
        out_job.a_neg  = an3_reg;
        if (az3_reg)
            out_job.status = ST_AZERO;
        else if (d_reg[DISC_W-1])
            out_job.status = ST_NONE;
        else if (d_reg == '0)
            out_job.status = ST_ONE;
        else
            out_job.status = ST_TWO;
    end
endmodule
`default_nettype wire

// File: rtl/qrs_queue.sv
// qrs_queue: short fifo between the front and back parts
// depends on qrs_pkg
`default_nettype none
module qrs_queue
    import qrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  job_t      wr_data,
    input  wire logic rd_en,
    output job_t      rd_data,
    output logic      not_empty
);
    localparam int AW = $clog2(QDEPTH);
    job_t          mem [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW-1:0] rp_next;
    logic [AW:0]   cnt_reg;
    job_t          rd_data_reg;

    assign rp_next = rd_en ? rp_reg + AW'(1) : rp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + AW'(1);
            rp_reg  <= rp_next;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
        // show-ahead head item, bypass when the head slot is written now
        if (wr_en && wp_reg == rp_next)
            rd_data_reg <= wr_data;
        else
            rd_data_reg <= mem[rp_next];
    end

    assign rd_data   = rd_data_reg;
    assign not_empty = (cnt_reg != '0);
endmodule
`default_nettype wire

// File: rtl/qrs_back.sv
// qrs_back: pipelined square root, two dividers and clamping
// depends on qrs_pkg
`default_nettype none
module qrs_back
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  job_t                    in_job,
    output logic                    out_valid,
    output status_t                 out_status,
    output logic signed [COEF_W-1:0] out_plus,
    output logic signed [COEF_W-1:0] out_minus,
    output logic                    out_sat
);
    // square root: one result bit per stage
    localparam int SN = SQRT_W;
    localparam int DW = NUM_W + FRAC_BITS + 1;  // dividend width
    localparam int VW = COEF_W + 1;             // divisor width (2|a|)
    localparam int QW = NUM_W + FRAC_BITS;      // quotient bits
    localparam int DV = QW;                     // divider stages

    job_t                 sj_reg [SN+1];
    logic [SQRT_W-1:0]    s_reg  [SN+1];
    logic [SN:0]          sv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= '0;
        else
            sv_reg <= {sv_reg[SN-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        sj_reg[0] <= in_job;
        s_reg[0]  <= '0;
    end

    for (genvar k = 0; k < SN; k++) begin : g_sq
        localparam int BIT = SN - 1 - k;
        logic [SQRT_W-1:0] t;
        logic [2*SQRT_W-1:0] t2;
        assign t  = s_reg[k] | (SQRT_W'(1) << BIT);
        assign t2 = t * t;
        always_ff @(posedge clk)
        begin
            sj_reg[k+1] <= sj_reg[k];
            s_reg[k+1]  <= (t2 <= (2*SQRT_W)'(sj_reg[k].disc)) ? t : s_reg[k];
        end
    end

    // rounding in two stages: round-up decision, then numerators
    logic [2*SQRT_W-1:0]    sq;
    logic [2*SQRT_W-1:0]    rem;
    logic [SQRT_W-1:0]      sr_reg;
    logic                   up_reg;
    job_t                   uj_reg;
    logic                   uv_reg;
    logic [SQRT_W-1:0]      sf;
    logic signed [NUM_W-1:0] np_reg, nm_reg;
    job_t                   rj_reg;
    logic                   rv_reg;

    assign sq  = s_reg[SN] * s_reg[SN];
    assign rem = (2*SQRT_W)'(sj_reg[SN].disc) - sq;
    assign sf  = up_reg ? sr_reg + SQRT_W'(1) : sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uv_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            uv_reg <= sv_reg[SN];
            rv_reg <= uv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        uj_reg <= sj_reg[SN];
        sr_reg <= s_reg[SN];
        up_reg <= rem > (2*SQRT_W)'(s_reg[SN]);
        rj_reg <= uj_reg;
        np_reg <= NUM_W'(uj_reg.negb) + NUM_W'({1'b0, sf});
        nm_reg <= NUM_W'(uj_reg.negb) - NUM_W'({1'b0, sf});
    end

    // restoring dividers, one quotient bit per stage, two lanes
    logic [DV:0]     dv_reg;
    job_t            dj_reg [DV+1];
    logic [VW-1:0]   dd_reg [DV+1];
    logic [QW-1:0]   qp_reg [DV+1], qm_reg [DV+1];
    logic [VW-1:0]   rp_reg [DV+1], rm_reg [DV+1];
    logic [DW-1:0]   xp_reg [DV+1], xm_reg [DV+1];
    logic            ngp_reg [DV+1], ngm_reg [DV+1];

    logic [NUM_W-1:0] unp, unm;
    assign unp = np_reg[NUM_W-1] ? NUM_W'(-np_reg) : NUM_W'(np_reg);
    assign unm = nm_reg[NUM_W-1] ? NUM_W'(-nm_reg) : NUM_W'(nm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else
            dv_reg <= {dv_reg[DV-1:0], rv_reg};
    end

    always_ff @(posedge clk)
    begin
        dj_reg[0]  <= rj_reg;
        dd_reg[0]  <= {rj_reg.mag_a, 1'b0};
        // (|n| << F) + |a|, then divide by 2|a|
        xp_reg[0]  <= DW'({unp, FRAC_BITS'(0)}) + DW'(rj_reg.mag_a);
        xm_reg[0]  <= DW'({unm, FRAC_BITS'(0)}) + DW'(rj_reg.mag_a);
        ngp_reg[0] <= np_reg[NUM_W-1] != rj_reg.a_neg;
        ngm_reg[0] <= nm_reg[NUM_W-1] != rj_reg.a_neg;
        qp_reg[0]  <= '0;
        qm_reg[0]  <= '0;
        rp_reg[0]  <= '0;
        rm_reg[0]  <= '0;
    end

    for (genvar k = 0; k < DV; k++) begin : g_div
        localparam int BIT = DW - 1 - k - (DW - QW);
        logic [VW:0] tp, tm;
        assign tp = {rp_reg[k], xp_reg[k][BIT]};
        assign tm = {rm_reg[k], xm_reg[k][BIT]};
        always_ff @(posedge clk)
        begin
            dj_reg[k+1]  <= dj_reg[k];
            dd_reg[k+1]  <= dd_reg[k];
            xp_reg[k+1]  <= xp_reg[k];
            xm_reg[k+1]  <= xm_reg[k];
            ngp_reg[k+1] <= ngp_reg[k];
            ngm_reg[k+1] <= ngm_reg[k];
            if (tp >= {1'b0, dd_reg[k]})
            begin
                rp_reg[k+1] <= VW'(tp - {1'b0, dd_reg[k]});
                qp_reg[k+1] <= {qp_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                rp_reg[k+1] <= VW'(tp);
                qp_reg[k+1] <= {qp_reg[k][QW-2:0], 1'b0};
            end
            if (tm >= {1'b0, dd_reg[k]})
            begin
                rm_reg[k+1] <= VW'(tm - {1'b0, dd_reg[k]});
                qm_reg[k+1] <= {qm_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                rm_reg[k+1] <= VW'(tm);
                qm_reg[k+1] <= {qm_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    // clamp and sign
    function automatic logic [COEF_W:0] clamp(input logic [QW-1:0] q, input logic ng);
        logic [COEF_W-1:0] r;
        logic              s;
        begin
            s = 1'b0;
            if (ng)
            begin
                if (q > QW'(33'h80000000))
                begin
                    r = 32'h80000000;
                    s = 1'b1;
                end
                else
                    r = COEF_W'(-q);
            end
            else if (q > QW'(33'h7FFFFFFF))
            begin
                r = 32'h7FFFFFFF;
                s = 1'b1;
            end
            else
                r = COEF_W'(q);
            clamp = {s, r};
        end
    endfunction

    logic [COEF_W:0] cp, cm;
    status_t         st;
    assign cp = clamp(qp_reg[DV], ngp_reg[DV]);
    assign cm = clamp(qm_reg[DV], ngm_reg[DV]);
    assign st = dj_reg[DV].status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= dv_reg[DV];
    end

    always_ff @(posedge clk)
    begin
        out_status <= st;
        case (st)
            ST_ONE:
            begin
                out_plus  <= cp[COEF_W-1:0];
                out_minus <= cp[COEF_W-1:0];
                out_sat   <= cp[COEF_W];
            end
            ST_TWO:
            begin
                out_plus  <= cp[COEF_W-1:0];
                out_minus <= cm[COEF_W-1:0];
                out_sat   <= cp[COEF_W] | cm[COEF_W];
            end
            default:
            begin
                out_plus  <= '0;
                out_minus <= '0;
                out_sat   <= 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// testbench for quadratic_root_solver: drives coefficient triples, predicts roots
// with an exact bit-level model and checks every result item in order
// depends on rtl/qrs_pkg.sv and rtl/quadratic_root_solver.sv
module testbench;
    import qrs_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } coef_item_t;

    typedef struct {
        status_t            status;
        logic signed [31:0] rplus;
        logic signed [31:0] rminus;
        logic               sat;
    } roots_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic done;
    logic [1:0] root_status;
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
    logic saturated;

    coef_item_t pending_items[$];
    roots_t expected_roots[$];
    int errors = 0;
    int cycle_count = 0;
    bit stimulus_done = 0;
    int gap_left = 0;

    quadratic_root_solver u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .done(done), .root_status(root_status), .root_plus(root_plus),
        .root_minus(root_minus), .saturated(saturated)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // nearest integer square root of a nonnegative discriminant
    function automatic logic [33:0] isqrt_nearest(input logic [66:0] d);
        logic [33:0] s;
        logic [33:0] t;
        logic [67:0] sq;
        begin
            s = '0;
            for (int i = 33; i >= 0; i--)
            begin
                t = s | (34'd1 << i);
                sq = t * t;
                if (sq <= {1'b0, d})
                    s = t;
            end
            sq = s * s;
            // round up when d - s^2 exceeds s
            if ({1'b0, d} - sq > {34'd0, s})
                s = s + 1;
            return s;
        end
    endfunction

    // n * 2^F / (2a), rounded half away from zero, clamped to 32 bits
    function automatic logic signed [31:0] scaled_quotient(input logic signed [35:0] n,
            input logic signed [31:0] a, inout logic sat);
        logic [35:0] un;
        logic [32:0] ua;
        logic [63:0] q;
        logic neg;
        begin
            un = n[35] ? -n : n;
            ua = a[31] ? -{a[31], a} : {a[31], a};
            neg = n[35] != a[31];
            q = ({28'd0, un} << FRAC) + {31'd0, ua};
            q = q / ({31'd0, ua} << 1);
            if (neg)
            begin
                if (q > 64'h8000_0000)
                begin
                    q = 64'h8000_0000;
                    sat = 1'b1;
                end
                return -q[31:0];
            end
            if (q > 64'h7FFF_FFFF)
            begin
                q = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            return q[31:0];
        end
    endfunction

    function automatic roots_t solve_roots(input coef_item_t it);
        roots_t r;
        logic signed [66:0] disc;
        logic signed [35:0] negb;
        logic [33:0] s;
        logic sat;
        begin
            r.status = ST_NONE;
            r.rplus = '0;
            r.rminus = '0;
            r.sat = 1'b0;
            sat = 1'b0;
            if (it.a == 0)
            begin
                r.status = ST_AZERO;
                return r;
            end
            disc = 67'(it.b) * 67'(it.b) - 67'sd4 * 67'(it.a) * 67'(it.c);
            if (disc < 0)
                return r;
            negb = -36'(it.b);
            if (disc == 0)
            begin
                r.status = ST_ONE;
                r.rplus = scaled_quotient(negb, it.a, sat);
                r.rminus = r.rplus;
                r.sat = sat;
                return r;
            end
            s = isqrt_nearest(disc);
            r.status = ST_TWO;
            r.rplus = scaled_quotient(negb + 36'(s), it.a, sat);
            r.rminus = scaled_quotient(negb - 36'(s), it.a, sat);
            r.sat = sat;
            return r;
        end
    endfunction

    function automatic logic [31:0] rand_coef();
        int k;
        begin
            k = $urandom_range(0, 9);
            if (k < 3)
                return $urandom;
            if (k < 6)
                return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
            if (k < 8)
                return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
            return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        end
    endfunction

    task automatic push_item(input logic [31:0] a, input logic [31:0] b,
            input logic [31:0] c);
        coef_item_t it;
        begin
            it.a = a;
            it.b = b;
            it.c = c;
            pending_items.push_back(it);
        end
    endtask

    // fill the queue: directed corners first, then random triples
    initial
    begin
        int r1;
        int r2;
        logic signed [31:0] ra;
        logic signed [31:0] rb;
        rst_n = 1'b0;
        // a is zero
        push_item(0, 32'h0001_0000, 32'h0002_0000);
        push_item(0, 0, 0);
        // no real roots: x^2 + 1
        push_item(32'h0001_0000, 0, 32'h0001_0000);
        // one root: x^2 - 2x + 1
        push_item(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
        // two roots: x^2 - 3x + 2
        push_item(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
        // extremes of every field
        push_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        push_item(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_item(32'h0000_0001, 32'h8000_0000, 0);
        push_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
        push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // tiny a with large roots saturates
        push_item(32'h0000_0001, 32'h0100_0000, 0);
        // one root: a tiny, b even
        push_item(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
        push_item(32'hFFFF_0000, 0, 0);
        for (int i = 0; i < 1000; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // factored form (x - r1)(x - r2) scaled so disc is often zero
                r1 = $signed($urandom_range(0, 64)) - 32;
                r2 = ($urandom_range(0, 1) == 1) ? r1 : $signed($urandom_range(0, 64)) - 32;
                ra = ($urandom_range(0, 1) == 1) ? 32'sh0001_0000 : -32'sh0001_0000;
                rb = -(r1 + r2) * ra;
                push_item(ra, rb, r1 * r2 * ra);
            end
            else
                push_item(rand_coef(), rand_coef(), rand_coef());
        end
        stimulus_done = 1'b1;
    end

    // reset held low from the start, then released once
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: presents items with random gaps, most short and a few long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            coef_a <= '0;
            coef_b <= '0;
            coef_c <= '0;
            gap_left <= 0;
        end
        else
        begin
            coef_item_t it;
            if (start && !busy)
                expected_roots.push_back(solve_roots('{coef_a, coef_b, coef_c}));
            if (start && busy)
            begin
                // hold the item until accepted
            end
            else if (gap_left > 0 || pending_items.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                it = pending_items.pop_front();
                start <= 1'b1;
                coef_a <= it.a;
                coef_b <= it.b;
                coef_c <= it.c;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:  gap_left <= $urandom_range(1, 3);
                    4:           gap_left <= $urandom_range(10, 60);
                    default:     gap_left <= 0;
                endcase
            end
        end
    end

    // monitor: every done strobe is checked against the oldest prediction
    always @(posedge clk)
    begin
        roots_t exp_r;
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, root_status);
                errors <= errors + 1;
            end
            else
            begin
                exp_r = expected_roots.pop_front();
                if (root_status !== exp_r.status || root_plus !== exp_r.rplus ||
                    root_minus !== exp_r.rminus || saturated !== exp_r.sat)
                begin
                    $display("%0t: expected status=%0d plus=%h minus=%h sat=%b",
                             $time, exp_r.status, exp_r.rplus, exp_r.rminus, exp_r.sat);
                    $display("%0t: actual   status=%0d plus=%h minus=%h sat=%b",
                             $time, root_status, root_plus, root_minus, saturated);
                    errors <= errors + 1;
                end
            end
        end
    end

    // end of run: drain, settle, then report
    initial
    begin
        wait (stimulus_done && pending_items.size() == 0 && !start
              && expected_roots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && expected_roots.size() == 0)
            $display("quadratic_root_solver: match");
        else
            $display("quadratic_root_solver: mismatch");
        $finish;
    end

    // watchdog on cycle count
    initial
    begin
        wait (cycle_count >= MAX_CYCLES);
        $display("quadratic_root_solver: mismatch");
        $finish;
    end
endmodule
